/* rtl/htfd_pkg.sv */
// package: frame codes, status codes, scaling constants and the crc-8 byte step
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

  localparam int DataW   = 8;
  localparam int WordW   = 16;
  localparam int TempW   = 15;
  localparam int HumW    = 7;
  localparam int StatusW = 2;
  localparam int PosW    = 3;

  // byte positions inside the six byte frame
  localparam logic [PosW-1:0] POS_TEMP_HI = 3'd0;
  localparam logic [PosW-1:0] POS_TEMP_LO = 3'd1;
  localparam logic [PosW-1:0] POS_TEMP_CRC = 3'd2;
  localparam logic [PosW-1:0] POS_HUM_HI = 3'd3;
  localparam logic [PosW-1:0] POS_HUM_LO = 3'd4;
  localparam logic [PosW-1:0] POS_HUM_CRC = 3'd5;
  localparam logic [PosW-1:0] POS_IDLE = 3'd6;

  localparam logic [StatusW-1:0] STATUS_OK = 2'd0;
  localparam logic [StatusW-1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [StatusW-1:0] STATUS_HUM_CRC = 2'd2;

  localparam logic [DataW-1:0] CRC_POLY = 8'h31;
  localparam logic [DataW-1:0] CRC_INIT = 8'hFF;

  localparam int TempProdW = 31;  // 65535 * 17500 fits
  localparam int HumProdW = 23;   // 65535 * 100 fits
  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [6:0] HUM_SPAN = 7'd100;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  typedef struct packed {
    logic [WordW-1:0]   temp_word;
    logic [WordW-1:0]   hum_word;
    logic [StatusW-1:0] status;
  } frame_t;

  function automatic logic [DataW-1:0] crc8_step(input logic [DataW-1:0] crc,
                                                 input logic [DataW-1:0] b);
    logic [DataW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/htfd_frame.sv */
// frame assembler: byte position, per-word crc-8 and the registered complete frame
`timescale 1ns / 1ps
`default_nettype none

module htfd_frame (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [htfd_pkg::DataW-1:0] data_byte,
  input  wire logic                      frame_start,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      down_ready,
  output logic                           frame_valid,
  output htfd_pkg::frame_t               frame
);

  logic [htfd_pkg::PosW-1:0]  pos;
  logic [htfd_pkg::PosW-1:0]  pos_next;
  logic [htfd_pkg::DataW-1:0] crc;
  logic [htfd_pkg::DataW-1:0] crc_next;
  logic [htfd_pkg::WordW-1:0] temp_word;
  logic [htfd_pkg::WordW-1:0] temp_word_next;
  logic                       temp_ok;
  logic                       temp_ok_next;
  logic [htfd_pkg::DataW-1:0] hum_high;
  logic [htfd_pkg::DataW-1:0] hum_high_next;
  logic [htfd_pkg::DataW-1:0] hum_low;
  logic [htfd_pkg::DataW-1:0] hum_low_next;
  logic [htfd_pkg::PosW-1:0]  cur_pos;
  logic [htfd_pkg::DataW-1:0] crc_step;
  logic                       accept;
  logic                       done;
  htfd_pkg::frame_t           frame_next;

  assign in_stall = frame_valid && !down_ready;
  assign accept   = in_valid && !in_stall;
  assign cur_pos  = frame_start ? htfd_pkg::POS_TEMP_HI : pos;

  // start of a word restarts from the init value
  assign crc_step = htfd_pkg::crc8_step(
    (cur_pos == htfd_pkg::POS_TEMP_HI || cur_pos == htfd_pkg::POS_HUM_HI) ?
    htfd_pkg::CRC_INIT : crc, data_byte);

  always_comb begin
    pos_next       = pos;
    crc_next       = crc;
    temp_word_next = temp_word;
    temp_ok_next   = temp_ok;
    hum_high_next  = hum_high;
    hum_low_next   = hum_low;
    done           = 1'b0;
    frame_next.temp_word = temp_word;
    frame_next.hum_word  = {hum_high, hum_low};
    frame_next.status    = htfd_pkg::STATUS_OK;
    if (!temp_ok) begin
      frame_next.status = htfd_pkg::STATUS_TEMP_CRC;
    end else if (crc != data_byte) begin
      frame_next.status = htfd_pkg::STATUS_HUM_CRC;
    end
    unique case (cur_pos)
      htfd_pkg::POS_TEMP_HI: begin
        crc_next       = crc_step;
        temp_word_next = {data_byte, 8'h00};
        pos_next       = htfd_pkg::POS_TEMP_LO;
      end
      htfd_pkg::POS_TEMP_LO: begin
        crc_next       = crc_step;
        temp_word_next = {temp_word[15:8], data_byte};
        pos_next       = htfd_pkg::POS_TEMP_CRC;
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_ok_next = (crc == data_byte);
        crc_next     = htfd_pkg::CRC_INIT;
        pos_next     = htfd_pkg::POS_HUM_HI;
      end
      htfd_pkg::POS_HUM_HI: begin
        crc_next      = crc_step;
        hum_high_next = data_byte;
        pos_next      = htfd_pkg::POS_HUM_LO;
      end
      htfd_pkg::POS_HUM_LO: begin
        crc_next     = crc_step;
        hum_low_next = data_byte;
        pos_next     = htfd_pkg::POS_HUM_CRC;
      end
      htfd_pkg::POS_HUM_CRC: begin
        crc_next = htfd_pkg::CRC_INIT;
        pos_next = htfd_pkg::POS_IDLE;
        done     = 1'b1;
      end
      default: begin
        // idle and the unused code: byte is dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= htfd_pkg::POS_TEMP_HI;
      crc         <= htfd_pkg::CRC_INIT;
      temp_word   <= '0;
      temp_ok     <= 1'b0;
      hum_high    <= '0;
      hum_low     <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos       <= pos_next;
        crc       <= crc_next;
        temp_word <= temp_word_next;
        temp_ok   <= temp_ok_next;
        hum_high  <= hum_high_next;
        hum_low   <= hum_low_next;
      end
      if (accept && done) begin
        frame_valid <= 1'b1;
      end else if (down_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/htfd_scale.sv */
// scaler: product stage, divide by 65535 and offset, result register
`timescale 1ns / 1ps
`default_nettype none

module htfd_scale (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          frame_valid,
  input  wire htfd_pkg::frame_t              frame,
  output logic                               up_ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [htfd_pkg::TempW-1:0]  temperature_centi,
  output logic [htfd_pkg::HumW-1:0]          humidity_percent,
  output logic [htfd_pkg::StatusW-1:0]       frame_status
);

  logic                             prod_valid;
  logic [htfd_pkg::TempProdW-1:0]   temp_prod;
  logic [htfd_pkg::HumProdW-1:0]    hum_prod;
  logic [htfd_pkg::StatusW-1:0]     prod_status;
  logic                             out_ready;
  logic [31:0]                      temp_sum;
  logic [23:0]                      hum_sum;
  logic [15:0]                      temp_quot;
  logic [15:0]                      temp_value;
  logic [htfd_pkg::HumW-1:0]        hum_quot;

  assign out_ready = !out_valid || !out_stall;
  assign up_ready  = !prod_valid || out_ready;

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for products in range
  assign temp_sum   = {1'b0, temp_prod} + 32'(temp_prod[30:16]) + 32'd1;
  assign hum_sum    = {1'b0, hum_prod} + 24'(hum_prod[22:16]) + 24'd1;
  assign temp_quot  = temp_sum[31:16];
  assign hum_quot   = hum_sum[22:16];
  assign temp_value = temp_quot - htfd_pkg::TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        prod_valid <= frame_valid;
      end
      if (out_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && frame_valid) begin
      temp_prod   <= htfd_pkg::TempProdW'(frame.temp_word) * htfd_pkg::TEMP_SPAN;
      hum_prod    <= htfd_pkg::HumProdW'(frame.hum_word) * htfd_pkg::HUM_SPAN;
      prod_status <= frame.status;
    end
    if (out_ready && prod_valid) begin
      frame_status <= prod_status;
      if (prod_status == htfd_pkg::STATUS_OK) begin
        temperature_centi <= temp_value[htfd_pkg::TempW-1:0];
        humidity_percent  <= hum_quot;
      end else begin
        temperature_centi <= '0;
        humidity_percent  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/humidity_temp_frame_decoder_unit.sv */
// top level: sensor frame decoder, frame assembler feeding the scaler
//
// input channel: one frame byte per item on data_byte, frame_start high on
// the first byte of a six byte frame (temperature word, its crc-8, humidity
// word, its crc-8, words big endian, crc-8 poly 0x31 init 0xff per word).
// a byte without frame_start after a complete frame is dropped.
// output channel: one item per complete frame with temperature_centi
// (hundredths of a degree), humidity_percent and frame_status
// (0 ok, 1 temperature crc bad, 2 humidity crc bad; values zero on error).
// throughput: one byte per cycle while in_stall is low. the sixth byte
// completes the frame register; the item then passes the product register
// and the result register, and the divide by 65535 is an add and shift
// after the product register.
// reset clears the byte position to the first byte and empties all stages.
// when the receiver stalls, results back up through the two stages; in_stall
// rises only once the frame register holds a frame that cannot move on.
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [htfd_pkg::DataW-1:0]    data_byte,
  input  wire logic                          frame_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [htfd_pkg::TempW-1:0]  temperature_centi,
  output logic [htfd_pkg::HumW-1:0]          humidity_percent,
  output logic [htfd_pkg::StatusW-1:0]       frame_status
);

  logic             frame_valid;
  logic             scale_ready;
  htfd_pkg::frame_t frame;

  htfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .down_ready  (scale_ready),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  htfd_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (frame_valid),
    .frame             (frame),
    .up_ready          (scale_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_percent  (humidity_percent),
    .frame_status      (frame_status)
  );

endmodule

`default_nettype wire

/* rtl/htfd_checker.sv */
// port checker for the frame decoder and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module htfd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [htfd_pkg::TempW-1:0] temperature_centi,
  input wire logic [htfd_pkg::HumW-1:0]     humidity_percent,
  input wire logic [htfd_pkg::StatusW-1:0]  frame_status
);

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temperature_centi) &&
      $stable(humidity_percent) && $stable(frame_status))
    else $error("stalled result item changed");

  // the input side only backs up once the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room downstream");

  // a crc failure zeroes the readings
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != htfd_pkg::STATUS_OK |->
      temperature_centi == '0 && humidity_percent == '0)
    else $error("readings not zero on crc error");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == htfd_pkg::STATUS_OK |->
      humidity_percent <= 7'd100 && temperature_centi >= -15'sd4500 &&
      temperature_centi <= 15'sd13000)
    else $error("reading out of range");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .temperature_centi (temperature_centi),
  .humidity_percent  (humidity_percent),
  .frame_status      (frame_status)
);

`default_nettype wire

/* verif/humidity_temp_frame_decoder_unit_tb.sv */
// testbench for the sensor frame decoder: random and directed frames checked against a predictor
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_unit_tb;

  localparam int RawFull = 65535;
  localparam int StallHold = 400;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 10;
  localparam int ItemTarget = 750;

  typedef struct {
    logic signed [htfd_pkg::TempW-1:0] temp;
    logic [htfd_pkg::HumW-1:0]         hum;
    logic [htfd_pkg::StatusW-1:0]      status;
  } reading_t;

  // predicts readings from accepted bytes and checks the readings that come out
  class reading_board;
    logic [htfd_pkg::PosW-1:0]  next_pos;
    logic [htfd_pkg::DataW-1:0] word_crc;
    logic [htfd_pkg::WordW-1:0] temp_raw;
    bit                         temp_crc_good;
    logic [htfd_pkg::DataW-1:0] hum_hi;
    logic [htfd_pkg::DataW-1:0] hum_lo;
    reading_t                   expected_q[$];
    int                         failures;
    int                         results_seen;
    int                         active_items;

    function new();
      next_pos = htfd_pkg::POS_TEMP_HI;
      word_crc = htfd_pkg::CRC_INIT;
      temp_raw = '0;
      temp_crc_good = 0;
      hum_hi = '0;
      hum_lo = '0;
      failures = 0;
      results_seen = 0;
      active_items = 0;
    endfunction

    // bit-serial crc-8, msb first
    static function logic [htfd_pkg::DataW-1:0] crc_update(logic [htfd_pkg::DataW-1:0] crc,
                                                           logic [htfd_pkg::DataW-1:0] b);
      logic [htfd_pkg::DataW-1:0] c;
      bit fb;
      c = crc;
      for (int i = htfd_pkg::DataW - 1; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c = {c[6:0], 1'b0};
        if (fb) c = c ^ htfd_pkg::CRC_POLY;
      end
      return c;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      failures++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    task note_input(logic [htfd_pkg::DataW-1:0] b, logic start);
      logic [htfd_pkg::PosW-1:0] pos_now;
      reading_t r;
      int t;
      pos_now = start ? htfd_pkg::POS_TEMP_HI : next_pos;
      if (pos_now <= htfd_pkg::POS_HUM_CRC) active_items++;
      case (pos_now)
        htfd_pkg::POS_TEMP_HI: begin
          word_crc = crc_update(htfd_pkg::CRC_INIT, b);
          temp_raw = {b, 8'h00};
          next_pos = htfd_pkg::POS_TEMP_LO;
        end
        htfd_pkg::POS_TEMP_LO: begin
          word_crc = crc_update(word_crc, b);
          temp_raw[7:0] = b;
          next_pos = htfd_pkg::POS_TEMP_CRC;
        end
        htfd_pkg::POS_TEMP_CRC: begin
          temp_crc_good = (word_crc == b);
          word_crc = htfd_pkg::CRC_INIT;
          next_pos = htfd_pkg::POS_HUM_HI;
        end
        htfd_pkg::POS_HUM_HI: begin
          word_crc = crc_update(htfd_pkg::CRC_INIT, b);
          hum_hi = b;
          next_pos = htfd_pkg::POS_HUM_LO;
        end
        htfd_pkg::POS_HUM_LO: begin
          word_crc = crc_update(word_crc, b);
          hum_lo = b;
          next_pos = htfd_pkg::POS_HUM_CRC;
        end
        htfd_pkg::POS_HUM_CRC: begin
          r.temp = '0;
          r.hum = '0;
          if (!temp_crc_good) begin
            r.status = htfd_pkg::STATUS_TEMP_CRC;
          end else if (word_crc != b) begin
            r.status = htfd_pkg::STATUS_HUM_CRC;
          end else begin
            r.status = htfd_pkg::STATUS_OK;
            t = (int'(temp_raw) * int'(htfd_pkg::TEMP_SPAN)) / RawFull -
                int'(htfd_pkg::TEMP_OFFSET);
            r.temp = t[htfd_pkg::TempW-1:0];
            r.hum = htfd_pkg::HumW'((int'({hum_hi, hum_lo}) * int'(htfd_pkg::HUM_SPAN)) /
                                    RawFull);
          end
          expected_q.push_back(r);
          word_crc = htfd_pkg::CRC_INIT;
          next_pos = htfd_pkg::POS_IDLE;
        end
        default: begin
          // idle: bytes without a start flag are dropped
        end
      endcase
    endtask

    task check_result(logic signed [htfd_pkg::TempW-1:0] t, logic [htfd_pkg::HumW-1:0] h,
                      logic [htfd_pkg::StatusW-1:0] s);
      reading_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item t=%0d h=%0d s=%0d", t, h, s));
        return;
      end
      want = expected_q.pop_front();
      if (t !== want.temp)
        report_mismatch($sformatf("temperature_centi got %0d want %0d", t, want.temp));
      if (h !== want.hum)
        report_mismatch($sformatf("humidity_percent got %0d want %0d", h, want.hum));
      if (s !== want.status)
        report_mismatch($sformatf("frame_status got %0d want %0d", s, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [htfd_pkg::DataW-1:0] data_byte;
  logic frame_start;
  logic out_valid;
  logic out_stall;
  logic signed [htfd_pkg::TempW-1:0] temperature_centi;
  logic [htfd_pkg::HumW-1:0] humidity_percent;
  logic [htfd_pkg::StatusW-1:0] frame_status;

  reading_board board = new();
  int idle_cycles = 0;

  humidity_temp_frame_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .temperature_centi(temperature_centi),
    .humidity_percent(humidity_percent),
    .frame_status(frame_status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_byte(input logic [htfd_pkg::DataW-1:0] b, input logic start);
    bit quiet;
    quiet = (board.active_items >= 300) && (board.active_items < 450);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_start <= start;
    do @(posedge clk); while (in_stall);
    board.note_input(b, start);
  endtask

  task automatic send_frame(input logic [htfd_pkg::WordW-1:0] tw,
                            input logic [htfd_pkg::WordW-1:0] hw,
                            input logic [htfd_pkg::DataW-1:0] t_flip,
                            input logic [htfd_pkg::DataW-1:0] h_flip,
                            input logic start);
    logic [htfd_pkg::DataW-1:0] tc;
    logic [htfd_pkg::DataW-1:0] hc;
    tc = reading_board::crc_update(reading_board::crc_update(htfd_pkg::CRC_INIT, tw[15:8]),
                                   tw[7:0]);
    hc = reading_board::crc_update(reading_board::crc_update(htfd_pkg::CRC_INIT, hw[15:8]),
                                   hw[7:0]);
    send_byte(tw[15:8], start);
    send_byte(tw[7:0], 1'b0);
    send_byte(tc ^ t_flip, 1'b0);
    send_byte(hw[15:8], 1'b0);
    send_byte(hw[7:0], 1'b0);
    send_byte(hc ^ h_flip, 1'b0);
  endtask

  function automatic logic [htfd_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return htfd_pkg::WordW'($urandom);
    endcase
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(temperature_centi, humidity_percent, frame_status);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, and a window with no stalls
  initial begin
    bit held;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && board.results_seen >= 20) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (StallHold) @(posedge clk);
      end
      // same window as the sender so neither side idles there
      if (board.active_items >= 300 && board.active_items < 450)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < 8);
    end
  end

  initial begin
    int kind;
    int n;
    logic [htfd_pkg::DataW-1:0] tf;
    logic [htfd_pkg::DataW-1:0] hf;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= '0;
    frame_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first frame after reset without a start flag, lowest raw values
    send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0);
    // idle after a complete frame, these are dropped
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1);
    // partial frame cut short by a new start
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    // both crcs bad: temperature error wins
    send_frame(16'h6666, 16'h8000, 8'hFF, 8'h01, 1'b1);
    send_frame(16'h1234, 16'hABCD, 8'h00, 8'h80, 1'b1);

    while (board.active_items < ItemTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        tf = 8'h00;
        hf = 8'h00;
        case ($urandom_range(0, 19))
          0, 1: tf = htfd_pkg::DataW'($urandom_range(1, 255));
          2, 3: hf = htfd_pkg::DataW'($urandom_range(1, 255));
          default: ;
        endcase
        send_frame(pick_word(), pick_word(), tf, hf, 1'b1);
      end else if (kind < 93) begin
        n = $urandom_range(1, 5);
        send_byte(htfd_pkg::DataW'($urandom), 1'b1);
        repeat (n - 1) send_byte(htfd_pkg::DataW'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(htfd_pkg::DataW'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
